FILE: src/ucer_pkg.sv
`default_nettype none
package ucer_pkg;

  typedef enum logic [1:0] {
    EV_SETUP     = 2'd0,
    EV_IN_ACK    = 2'd1,
    EV_BUS_RESET = 2'd2,
    EV_NONE      = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    OP_NOP       = 3'd0,
    OP_STALL     = 3'd1,
    OP_SET_ADDR  = 3'd2,
    OP_SET_CFG   = 3'd3,
    OP_START     = 3'd4,
    OP_IN        = 3'd5,
    OP_BUS_RESET = 3'd6
  } op_e;

  localparam logic [7:0] REQ_SET_ADDRESS = 8'd5;
  localparam logic [7:0] REQ_GET_DESC    = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIG  = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIG  = 8'd9;

  localparam logic [7:0] DESC_DEVICE = 8'd1;
  localparam logic [7:0] DESC_CONFIG = 8'd2;
  localparam logic [7:0] DESC_STRING = 8'd3;

  localparam logic [7:0] STR_LANG    = 8'd0;
  localparam logic [7:0] STR_PRODUCT = 8'd1;
  localparam logic [7:0] STR_MANUF   = 8'd2;

  localparam logic [2:0] SEL_DEVICE  = 3'd0;
  localparam logic [2:0] SEL_CONFIG  = 3'd1;
  localparam logic [2:0] SEL_LANG    = 3'd2;
  localparam logic [2:0] SEL_PRODUCT = 3'd3;
  localparam logic [2:0] SEL_MANUF   = 3'd4;
  localparam logic [2:0] SEL_CFG_VAL = 3'd5;

  localparam logic [5:0] DEV_LEN  = 6'd18;
  localparam logic [5:0] CFG_LEN  = 6'd32;
  localparam logic [5:0] LANG_LEN = 6'd4;
  localparam logic [5:0] PROD_LEN = 6'd14;
  localparam logic [5:0] MANU_LEN = 6'd22;

  localparam int unsigned MAX_PACKET_BYTES = 8;

  localparam logic [1:0] REG_VEND_CODE   = 2'd0;
  localparam logic [1:0] REG_PROD_CODE   = 2'd1;
  localparam logic [1:0] REG_PRODUCT_VER = 2'd2;
  localparam logic [1:0] REG_OWN_POWER   = 2'd3;

  localparam logic [7:0] PROD_TAB [14] = '{
    8'd14, 8'd3, 8'h49, 8'h00, 8'h52, 8'h00, 8'h20, 8'h00, 8'h42, 8'h00,
    8'h6F, 8'h00, 8'h79, 8'h00
  };
  localparam logic [7:0] MANU_TAB [22] = '{
    8'd22, 8'd3, 8'h49, 8'h00, 8'h20, 8'h00, 8'h4D, 8'h00, 8'h61, 8'h00,
    8'h64, 8'h00, 8'h65, 8'h00, 8'h20, 8'h00, 8'h49, 8'h00, 8'h74, 8'h00,
    8'h21, 8'h00
  };
  localparam logic [7:0] CFG_TAIL [23] = '{
    8'd9, 8'd4, 8'h00, 8'h00, 8'd2, 8'hFF, 8'h01, 8'hFF, 8'h00,
    8'd7, 8'd5, 8'h81, 8'h03, 8'd8, 8'h00, 8'h01,
    8'd7, 8'd5, 8'h02, 8'h03, 8'd8, 8'h00, 8'h01
  };

  typedef struct packed {
    op_e        op;
    logic [2:0] sel;
    logic [5:0] end_pos;
    logic [6:0] arg;
  } cmd_t;

  typedef struct packed {
    logic [15:0] vend_code;
    logic [15:0] prod_code;
    logic [15:0] product_version;
    logic        own_power;
  } regs_t;

  typedef struct packed {
    logic        send_valid;
    logic        stall_flag;
    logic [63:0] packet_bytes;
    logic [3:0]  byte_count;
    logic        data_toggle;
    logic [6:0]  device_address;
    logic        configured;
  } res_t;

  function automatic logic [7:0] dev_byte(logic [5:0] idx, regs_t regs);
    logic [7:0] b;
    b = 8'h00;
    unique case (idx)
      6'd0:    b = 8'd18;
      6'd1:    b = 8'd1;
      6'd2:    b = 8'h10;
      6'd3:    b = 8'h01;
      6'd7:    b = 8'd8;
      6'd8:    b = regs.vend_code[7:0];
      6'd9:    b = regs.vend_code[15:8];
      6'd10:   b = regs.prod_code[7:0];
      6'd11:   b = regs.prod_code[15:8];
      6'd12:   b = regs.product_version[7:0];
      6'd13:   b = regs.product_version[15:8];
      6'd14:   b = 8'd2;
      6'd15:   b = 8'd1;
      6'd17:   b = 8'd1;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] cfg_byte(logic [5:0] idx, regs_t regs);
    logic [7:0] b;
    b = 8'h00;
    unique case (idx)
      6'd0:    b = 8'd9;
      6'd1:    b = 8'd2;
      6'd2:    b = 8'(CFG_LEN);
      6'd3:    b = 8'd0;
      6'd4:    b = 8'd1;
      6'd5:    b = 8'd1;
      6'd6:    b = 8'd0;
      6'd7:    b = regs.own_power ? 8'hC0 : 8'h80;
      6'd8:    b = regs.own_power ? 8'd0 : 8'd100;
      default: b = (idx < CFG_LEN) ? CFG_TAIL[5'(idx - 6'd9)] : 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] fetch_byte(logic [2:0] sel, logic [5:0] idx,
                                            regs_t regs, logic cfg_flag);
    logic [7:0] b;
    b = 8'h00;
    unique case (sel)
      SEL_DEVICE:  b = dev_byte(idx, regs);
      SEL_CONFIG:  b = cfg_byte(idx, regs);
      SEL_LANG: begin
        unique case (idx)
          6'd0:    b = 8'd4;
          6'd1:    b = 8'd3;
          6'd2:    b = 8'h09;
          6'd3:    b = 8'h04;
          default: b = 8'h00;
        endcase
      end
      SEL_PRODUCT: b = (idx < PROD_LEN) ? PROD_TAB[4'(idx)] : 8'h00;
      SEL_MANUF:   b = (idx < MANU_LEN) ? MANU_TAB[5'(idx)] : 8'h00;
      SEL_CFG_VAL: b = {7'd0, cfg_flag};
      default:     b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: src/usb_control_endpoint_responder.sv
// Endpoint-zero responder for a USB device: setup packets, IN acknowledgements and bus
// resets go in through a queue-like push port, and one result per event comes out in order
// through a queue-like pop port. Events are decoded on entry into a two-entry command queue;
// the execution stage retires one command per clock into a two-entry result queue while it
// has room, and a new event may be pushed every cycle while the command queue is not full.
// The configuration registers should be written only while no event is in flight.
`default_nettype none
module usb_control_endpoint_responder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  event_kind_i,
  input  wire logic [7:0]  request_type_i,
  input  wire logic [7:0]  request_code_i,
  input  wire logic [15:0] request_value_i,
  input  wire logic [15:0] request_length_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             send_valid_o,
  output logic             stall_flag_o,
  output logic [63:0]      packet_bytes_o,
  output logic [3:0]       byte_count_o,
  output logic             data_toggle_o,
  output logic [6:0]       device_address_o,
  output logic             configured_o
);
  import ucer_pkg::*;

  cmd_t dec_cmd;
  cmd_t head_cmd;
  logic cmd_empty;
  logic cmd_pop;
  res_t res;

  ucer_front u_front (
    .event_kind_i    (event_kind_i),
    .request_type_i  (request_type_i),
    .request_code_i  (request_code_i),
    .request_value_i (request_value_i),
    .request_length_i(request_length_i),
    .cmd_o           (dec_cmd)
  );

  ucer_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (dec_cmd),
    .full_o (full),
    .pop_i  (cmd_pop),
    .cmd_o  (head_cmd),
    .empty_o(cmd_empty)
  );

  ucer_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (head_cmd),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .res_o      (res),
    .res_empty_o(empty),
    .res_pop_i  (pop)
  );

  assign send_valid_o     = res.send_valid;
  assign stall_flag_o     = res.stall_flag;
  assign packet_bytes_o   = res.packet_bytes;
  assign byte_count_o     = res.byte_count;
  assign data_toggle_o    = res.data_toggle;
  assign device_address_o = res.device_address;
  assign configured_o     = res.configured;

endmodule
`default_nettype wire

FILE: src/ucer_front.sv
`default_nettype none
module ucer_front (
  input  wire logic [1:0]      event_kind_i,
  input  wire logic [7:0]      request_type_i,
  input  wire logic [7:0]      request_code_i,
  input  wire logic [15:0]     request_value_i,
  input  wire logic [15:0]     request_length_i,
  output ucer_pkg::cmd_t       cmd_o
);
  import ucer_pkg::*;

  logic [5:0] full_len;

  function automatic logic [5:0] trim(logic [15:0] len, logic [5:0] full);
    return (len < {10'd0, full}) ? len[5:0] : full;
  endfunction

  always_comb begin
    cmd_o.op      = OP_NOP;
    cmd_o.sel     = SEL_DEVICE;
    cmd_o.end_pos = 6'd0;
    cmd_o.arg     = 7'd0;
    full_len      = 6'd0;
    unique case (event_e'(event_kind_i))
      EV_SETUP: begin
        cmd_o.op = OP_STALL;
        if (request_type_i[6:0] == 7'd0) begin
          priority case (request_code_i)
            REQ_SET_ADDRESS: begin
              cmd_o.op  = OP_SET_ADDR;
              cmd_o.arg = request_value_i[6:0];
            end
            REQ_GET_DESC: begin
              priority case (request_value_i[15:8])
                DESC_DEVICE: begin
                  cmd_o.op  = OP_START;
                  cmd_o.sel = SEL_DEVICE;
                  full_len  = DEV_LEN;
                end
                DESC_CONFIG: begin
                  cmd_o.op  = OP_START;
                  cmd_o.sel = SEL_CONFIG;
                  full_len  = CFG_LEN;
                end
                DESC_STRING: begin
                  priority case (request_value_i[7:0])
                    STR_LANG: begin
                      cmd_o.op  = OP_START;
                      cmd_o.sel = SEL_LANG;
                      full_len  = LANG_LEN;
                    end
                    STR_PRODUCT: begin
                      cmd_o.op  = OP_START;
                      cmd_o.sel = SEL_PRODUCT;
                      full_len  = PROD_LEN;
                    end
                    STR_MANUF: begin
                      cmd_o.op  = OP_START;
                      cmd_o.sel = SEL_MANUF;
                      full_len  = MANU_LEN;
                    end
                    default: cmd_o.op = OP_STALL;
                  endcase
                end
                default: cmd_o.op = OP_STALL;
              endcase
            end
            REQ_GET_CONFIG: begin
              cmd_o.op  = OP_START;
              cmd_o.sel = SEL_CFG_VAL;
              full_len  = 6'd1;
            end
            REQ_SET_CONFIG: begin
              if (request_value_i == 16'd1 || request_value_i == 16'd0) begin
                cmd_o.op  = OP_SET_CFG;
                cmd_o.arg = {6'd0, request_value_i[0]};
              end
            end
            default: cmd_o.op = OP_STALL;
          endcase
        end
        cmd_o.end_pos = trim(request_length_i, full_len);
      end
      EV_IN_ACK:    cmd_o.op = OP_IN;
      EV_BUS_RESET: cmd_o.op = OP_BUS_RESET;
      default:      cmd_o.op = OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/ucer_cmd_fifo.sv
`default_nettype none
module ucer_cmd_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ucer_pkg::cmd_t  cmd_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output ucer_pkg::cmd_t       cmd_o,
  output logic                 empty_o
);
  import ucer_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

FILE: src/ucer_back.sv
`default_nettype none
module ucer_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_index_i,
  input  wire logic [15:0]     cfg_wdata_i,
  input  wire ucer_pkg::cmd_t  cmd_i,
  input  wire logic            cmd_empty_i,
  output logic                 cmd_pop_o,
  output ucer_pkg::res_t       res_o,
  output logic                 res_empty_o,
  input  wire logic            res_pop_i
);
  import ucer_pkg::*;

  regs_t      regs_q;
  logic [2:0] sel_q, sel_d;
  logic [5:0] pos_q, pos_d;
  logic [5:0] end_q, end_d;
  logic       last_q, last_d;
  logic       toggle_q, toggle_d;
  logic [6:0] pend_q, pend_d;
  logic [6:0] addr_q, addr_d;
  logic       cfgd_q, cfgd_d;

  res_t       res_q [2];
  res_t       res_d;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       res_push, res_pop;

  logic [2:0]  c_sel;
  logic [5:0]  c_pos, c_end, c_diff, c_idx;
  logic [3:0]  c_n;
  logic [63:0] c_bytes;
  logic        do_chunk;

  assign res_empty_o = (count_q == 2'd0);
  assign res_o       = res_q[rd_ptr_q];
  assign res_push    = !cmd_empty_i && (count_q != 2'd2);
  assign res_pop     = res_pop_i && !res_empty_o;
  assign cmd_pop_o   = res_push;

  always_comb begin
    sel_d    = sel_q;
    pos_d    = pos_q;
    end_d    = end_q;
    last_d   = last_q;
    toggle_d = toggle_q;
    pend_d   = pend_q;
    addr_d   = addr_q;
    cfgd_d   = cfgd_q;
    do_chunk = 1'b0;
    c_sel    = sel_q;
    c_pos    = pos_q;
    c_end    = end_q;
    res_d    = '0;
    unique case (cmd_i.op)
      OP_STALL: begin
        toggle_d = 1'b1;
        pos_d    = end_q;
        last_d   = 1'b1;
        res_d.stall_flag = 1'b1;
      end
      OP_SET_ADDR: begin
        toggle_d = 1'b1;
        pend_d   = cmd_i.arg;
        c_pos    = 6'd0;
        c_end    = 6'd0;
        do_chunk = 1'b1;
      end
      OP_SET_CFG: begin
        toggle_d = 1'b1;
        cfgd_d   = cmd_i.arg[0];
        c_pos    = 6'd0;
        c_end    = 6'd0;
        do_chunk = 1'b1;
      end
      OP_START: begin
        toggle_d = 1'b1;
        c_sel    = cmd_i.sel;
        c_pos    = 6'd0;
        c_end    = cmd_i.end_pos;
        do_chunk = 1'b1;
      end
      OP_IN: begin
        if (pend_q != 7'd0) begin
          addr_d = pend_q;
          pend_d = 7'd0;
        end
        if (!last_q) begin
          toggle_d = !toggle_q;
          do_chunk = 1'b1;
        end else begin
          last_d = 1'b0;
        end
      end
      OP_BUS_RESET: begin
        sel_d    = SEL_DEVICE;
        pos_d    = 6'd0;
        end_d    = 6'd0;
        last_d   = 1'b0;
        toggle_d = 1'b0;
        pend_d   = 7'd0;
        addr_d   = 7'd0;
        cfgd_d   = 1'b0;
      end
      default: ;
    endcase

    c_diff  = c_end - c_pos;
    c_n     = (c_diff > 6'(MAX_PACKET_BYTES)) ? 4'(MAX_PACKET_BYTES) : c_diff[3:0];
    c_bytes = '0;
    for (int k = 0; k < MAX_PACKET_BYTES; k++) begin
      c_idx = c_pos + 6'(k);
      if (4'(k) < c_n) begin
        c_bytes[8*k +: 8] = fetch_byte(c_sel, c_idx, regs_q, cfgd_d);
      end
    end

    if (do_chunk) begin
      sel_d = c_sel;
      pos_d = c_pos + {2'd0, c_n};
      end_d = c_end;
      last_d = ((c_pos + {2'd0, c_n}) == c_end) ? 1'b1 : 1'b0;
      res_d.send_valid   = 1'b1;
      res_d.packet_bytes = c_bytes;
      res_d.byte_count   = c_n;
      res_d.data_toggle  = toggle_d;
    end
    res_d.device_address = addr_d;
    res_d.configured     = cfgd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q   <= '0;
      sel_q    <= SEL_DEVICE;
      pos_q    <= 6'd0;
      end_q    <= 6'd0;
      last_q   <= 1'b0;
      toggle_q <= 1'b0;
      pend_q   <= 7'd0;
      addr_q   <= 7'd0;
      cfgd_q   <= 1'b0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_VEND_CODE:   regs_q.vend_code       <= cfg_wdata_i;
          REG_PROD_CODE:   regs_q.prod_code       <= cfg_wdata_i;
          REG_PRODUCT_VER: regs_q.product_version <= cfg_wdata_i;
          REG_OWN_POWER:   regs_q.own_power       <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (res_push) begin
        sel_q    <= sel_d;
        pos_q    <= pos_d;
        end_q    <= end_d;
        last_q   <= last_d;
        toggle_q <= toggle_d;
        pend_q   <= pend_d;
        addr_q   <= addr_d;
        cfgd_q   <= cfgd_d;
      end
      wr_ptr_q <= wr_ptr_q ^ res_push;
      rd_ptr_q <= rd_ptr_q ^ res_pop;
      count_q  <= count_q + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[wr_ptr_q] <= res_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/ucer_checker.sv
`default_nettype none
module ucer_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        send_valid_o,
  input wire logic        stall_flag_o,
  input wire logic [63:0] packet_bytes_o,
  input wire logic [3:0]  byte_count_o,
  input wire logic        data_toggle_o
);

  a_stall_not_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && stall_flag_o) |-> !send_valid_o)
    else $error("stall shown with an armed packet");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (byte_count_o <= 4'd8))
    else $error("byte count above packet size");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !send_valid_o) |->
      (packet_bytes_o == 64'd0 && byte_count_o == 4'd0 && data_toggle_o == 1'b0))
    else $error("payload present on an unarmed result");

  a_unused_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && byte_count_o == 4'd1) |-> (packet_bytes_o[63:8] == 56'd0))
    else $error("bytes beyond count are not zero");

endmodule

bind usb_control_endpoint_responder ucer_checker u_ucer_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .send_valid_o  (send_valid_o),
  .stall_flag_o  (stall_flag_o),
  .packet_bytes_o(packet_bytes_o),
  .byte_count_o  (byte_count_o),
  .data_toggle_o (data_toggle_o)
);
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import ucer_pkg::*;

  typedef struct {
    event_e      kind;
    logic [7:0]  rtype;
    logic [7:0]  code;
    logic [15:0] value;
    logic [15:0] length;
  } usb_event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  event_kind_i = '0;
  logic [7:0]  request_type_i = '0;
  logic [7:0]  request_code_i = '0;
  logic [15:0] request_value_i = '0;
  logic [15:0] request_length_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        send_valid_o;
  logic        stall_flag_o;
  logic [63:0] packet_bytes_o;
  logic [3:0]  byte_count_o;
  logic        data_toggle_o;
  logic [6:0]  device_address_o;
  logic        configured_o;

  usb_control_endpoint_responder u_top (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  usb_event_t event_q[$];
  res_t       reply_q[$];
  int         errors = 0;
  int         tx_idle_pct = 0;
  int         rx_stall_pct = 0;
  bit         rx_hold = 1'b0;
  int         phase_no = -1;

  // Device state mirrored by the predictor.
  logic [15:0] vid = '0, pid = '0, pver = '0;
  logic        selfpow = 1'b0;
  logic [2:0]  sel = '0;
  logic [5:0]  pos = '0, endp = '0;
  logic        last_sent = 1'b0, tog = 1'b0;
  logic [6:0]  pend_addr = '0, cur_addr = '0;
  logic        cfg_flag = 1'b0;

  logic [7:0] cfg_rest [23] = '{9, 4, 0, 0, 2, 8'hFF, 1, 8'hFF, 0,
                                7, 5, 8'h81, 3, 8, 0, 1, 7, 5, 2, 3, 8, 0, 1};
  logic [7:0] lang_str [4] = '{4, 3, 8'h09, 8'h04};
  logic [7:0] prod_str [14] = '{14, 3, 8'h49, 0, 8'h52, 0, 8'h20, 0, 8'h42, 0,
                                8'h6F, 0, 8'h79, 0};
  logic [7:0] manu_str [22] = '{22, 3, 8'h49, 0, 8'h20, 0, 8'h4D, 0, 8'h61, 0,
                                8'h64, 0, 8'h65, 0, 8'h20, 0, 8'h49, 0, 8'h74, 0,
                                8'h21, 0};

  function automatic logic [7:0] descriptor_byte(logic [5:0] i);
    logic [7:0] dev [18];
    dev = '{18, 1, 8'h10, 8'h01, 0, 0, 0, 8, vid[7:0], vid[15:8], pid[7:0], pid[15:8],
            pver[7:0], pver[15:8], 2, 1, 0, 1};
    case (sel)
      SEL_DEVICE:  return (i < DEV_LEN) ? dev[i] : 8'h00;
      SEL_CONFIG: begin
        case (i)
          0: return 8'd9;
          1: return 8'd2;
          2: return 8'd32;
          4, 5: return 8'd1;
          7: return selfpow ? 8'hC0 : 8'h80;
          8: return selfpow ? 8'd0 : 8'd100;
          default: return (i >= 9 && i < CFG_LEN) ? cfg_rest[i - 9] : 8'h00;
        endcase
      end
      SEL_LANG:    return (i < LANG_LEN) ? lang_str[i] : 8'h00;
      SEL_PRODUCT: return (i < PROD_LEN) ? prod_str[i] : 8'h00;
      SEL_MANUF:   return (i < MANU_LEN) ? manu_str[i] : 8'h00;
      SEL_CFG_VAL: return {7'd0, cfg_flag};
      default:     return 8'h00;
    endcase
  endfunction

  function automatic void next_chunk(ref res_t r);
    int n;
    n = 0;
    r.packet_bytes = '0;
    while (pos != endp && n != MAX_PACKET_BYTES) begin
      r.packet_bytes |= 64'(descriptor_byte(pos)) << (8 * n);
      n++;
      pos = pos + 6'd1;
    end
    if (pos == endp) last_sent = 1'b1;
    r.send_valid = 1'b1;
    r.byte_count = 4'(n);
    r.data_toggle = tog;
  endfunction

  function automatic void open_transfer(logic [2:0] s, logic [5:0] whole, logic [15:0] len);
    sel = s;
    pos = '0;
    endp = (len < whole) ? len[5:0] : whole;
  endfunction

  function automatic bit serve_setup(usb_event_t e, ref res_t r);
    if (e.rtype[6:0] != 7'd0) return 1'b1;
    case (e.code)
      REQ_SET_ADDRESS: begin
        pend_addr = e.value[6:0];
        pos = '0;
        endp = '0;
        next_chunk(r);
      end
      REQ_GET_DESC: begin
        case (e.value[15:8])
          DESC_DEVICE: open_transfer(SEL_DEVICE, DEV_LEN, e.length);
          DESC_CONFIG: open_transfer(SEL_CONFIG, CFG_LEN, e.length);
          DESC_STRING: begin
            case (e.value[7:0])
              STR_LANG:    open_transfer(SEL_LANG, LANG_LEN, e.length);
              STR_PRODUCT: open_transfer(SEL_PRODUCT, PROD_LEN, e.length);
              STR_MANUF:   open_transfer(SEL_MANUF, MANU_LEN, e.length);
              default:     return 1'b1;
            endcase
          end
          default: return 1'b1;
        endcase
        next_chunk(r);
      end
      REQ_GET_CONFIG: begin
        open_transfer(SEL_CFG_VAL, 6'd1, e.length);
        next_chunk(r);
      end
      REQ_SET_CONFIG: begin
        if (e.value == 16'd1) cfg_flag = 1'b1;
        else if (e.value == 16'd0) cfg_flag = 1'b0;
        else return 1'b1;
        pos = '0;
        endp = '0;
        next_chunk(r);
      end
      default: return 1'b1;
    endcase
    return 1'b0;
  endfunction

  function automatic res_t endpoint_reply(usb_event_t e);
    res_t r;
    r = '0;
    case (e.kind)
      EV_SETUP: begin
        last_sent = 1'b0;
        tog = 1'b1;
        if (serve_setup(e, r)) begin
          r = '0;
          r.stall_flag = 1'b1;
          pos = endp;
          last_sent = 1'b1;
        end
      end
      EV_IN_ACK: begin
        if (pend_addr != 7'd0) begin
          cur_addr = pend_addr;
          pend_addr = '0;
        end
        if (!last_sent) begin
          tog = ~tog;
          next_chunk(r);
        end else begin
          last_sent = 1'b0;
        end
      end
      EV_BUS_RESET: begin
        sel = '0; pos = '0; endp = '0; last_sent = 1'b0; tog = 1'b0;
        pend_addr = '0; cur_addr = '0; cfg_flag = 1'b0;
      end
      default: ;
    endcase
    r.device_address = cur_addr;
    r.configured = cfg_flag;
    return r;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni && event_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
      push <= 1'b1;
      event_kind_i <= event_q[0].kind;
      request_type_i <= event_q[0].rtype;
      request_code_i <= event_q[0].code;
      request_value_i <= event_q[0].value;
      request_length_i <= event_q[0].length;
    end else begin
      push <= 1'b0;
    end
    pop <= rst_ni && !rx_hold && $urandom_range(99) >= rx_stall_pct;
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && push && !full) reply_q.push_back(endpoint_reply(event_q.pop_front()));
    if (rst_ni && pop && !empty) begin
      if (reply_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer out, expected nothing, got %h", $time,
                 packet_bytes_o);
      end else begin
        want = reply_q.pop_front();
        check_field("send_valid", want.send_valid, send_valid_o);
        check_field("stall_flag", want.stall_flag, stall_flag_o);
        check_field("packet_bytes", want.packet_bytes, packet_bytes_o);
        check_field("byte_count", want.byte_count, byte_count_o);
        check_field("data_toggle", want.data_toggle, data_toggle_o);
        check_field("device_address", want.device_address, device_address_o);
        check_field("configured", want.configured, configured_o);
      end
    end
  end

  function automatic void add_event(event_e k, logic [7:0] rt, logic [7:0] c,
                                    logic [15:0] v, logic [15:0] l);
    usb_event_t e;
    e.kind = k; e.rtype = rt; e.code = c; e.value = v; e.length = l;
    event_q.push_back(e);
  endfunction

  function automatic void add_setup(logic [7:0] c, logic [15:0] v, logic [15:0] l, int acks);
    add_event(EV_SETUP, 8'h80, c, v, l);
    repeat (acks) add_event(EV_IN_ACK, 8'h00, 8'h00, 16'h0000, 16'h0000);
  endfunction

  function automatic int add_random_sequence();
    int before_n, pick;
    logic [15:0] v, l;
    before_n = event_q.size();
    pick = $urandom_range(99);
    l = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
    if (pick < 10) begin
      add_event(event_e'($urandom_range(3)), 8'($urandom), 8'($urandom), 16'($urandom),
                16'($urandom));
    end else if (pick < 13) begin
      add_event(EV_BUS_RESET, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
    end else if (pick < 20) begin
      add_event(EV_IN_ACK, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      case ($urandom_range(5))
        0: add_setup(REQ_SET_ADDRESS, 16'($urandom_range(127)), l, $urandom_range(2));
        1: add_setup(REQ_GET_CONFIG, 16'($urandom), l, $urandom_range(3));
        2: add_setup(REQ_SET_CONFIG, 16'($urandom_range(2)), l, $urandom_range(2));
        default: begin
          v = {8'($urandom_range(1, 4)), 8'($urandom_range(3))};
          if ($urandom_range(9) == 0) v = 16'($urandom);
          add_setup(REQ_GET_DESC, v, l, $urandom_range(6));
        end
      endcase
      event_q[before_n].rtype[7] = 1'($urandom);
      if ($urandom_range(15) == 0) event_q[before_n].rtype = 8'($urandom);
    end
    return event_q.size() - before_n;
  endfunction

  task automatic wait_idle();
    while (event_q.size() != 0 || reply_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [15:0] v, logic [15:0] p, logic [15:0] r, logic s);
    logic [1:0]  idx [4];
    logic [15:0] dat [4];
    idx = '{REG_VEND_CODE, REG_PROD_CODE, REG_PRODUCT_VER, REG_OWN_POWER};
    dat = '{v, p, r, {15'd0, s}};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_wdata_i <= dat[i];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    vid = v; pid = p; pver = r; selfpow = s;
  endtask

  initial begin
    rx_hold = 1'b0;
    wait (phase_no == 0);
    rx_hold = 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    int added;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at reset register values.
    add_event(EV_IN_ACK, 0, 0, 0, 0);
    add_setup(REQ_GET_DESC, 16'h0100, 16'hFFFF, 4);
    add_setup(REQ_GET_DESC, 16'h0200, 16'hFFFF, 5);
    add_setup(REQ_GET_DESC, 16'h0300, 16'd3, 1);
    add_setup(REQ_GET_DESC, 16'h0301, 16'd14, 2);
    add_setup(REQ_GET_DESC, 16'h0302, 16'd8, 1);
    add_setup(REQ_GET_DESC, 16'h0303, 16'd8, 1);
    add_setup(REQ_GET_DESC, 16'h0400, 16'd8, 0);
    add_setup(REQ_GET_DESC, 16'h0100, 16'd0, 1);
    add_setup(REQ_SET_CONFIG, 16'd1, 0, 1);
    add_setup(REQ_GET_CONFIG, 0, 16'd1, 1);
    add_setup(REQ_SET_CONFIG, 16'd2, 0, 1);
    add_setup(REQ_SET_CONFIG, 16'd0, 0, 0);
    add_setup(REQ_SET_ADDRESS, 16'h007F, 0, 1);
    add_setup(REQ_SET_ADDRESS, 16'h0000, 0, 1);
    add_event(EV_SETUP, 8'h21, REQ_GET_DESC, 16'h0100, 16'hFFFF);
    add_event(EV_IN_ACK, 0, 0, 0, 0);
    add_event(EV_NONE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    add_setup(8'hFF, 16'hFFFF, 16'hFFFF, 0);
    add_event(EV_BUS_RESET, 0, 0, 0, 0);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        3: write_regs(16'h0000, 16'h0000, 16'h0000, 1'b0);
        default: write_regs(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
      endcase
      tx_idle_pct = (ph == 1) ? 88 : (ph == 3) ? 7 : 0;
      rx_stall_pct = (ph == 2) ? 88 : (ph == 3) ? 7 : 0;
      added = 0;
      while (added < 425) added += add_random_sequence();
      phase_no = ph;
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
